/* design/ntc_adc_to_temperature_unit_macros.svh */
// Assertion macros shared by the NTC temperature unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NTC_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define NTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define NTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ntc_pkg.sv */
// Shared types, constants and the thermistor code list for the NTC unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntc_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int TEMP_BITS     = 17;
	localparam int OFFSET_BITS   = 8;
	localparam int START_BITS    = 7;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;
	localparam int MAX_ENTRIES_W = 10;
	localparam int LISTED_CODES  = 200;
	localparam int QUOT_MAX_W    = 17;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET            = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_START_TEMPERATURE = CFG_IDX_W'(1);

	localparam logic [OFFSET_BITS-1:0]       OFFSET_RESET = '0;
	localparam logic signed [START_BITS-1:0] START_RESET  = -7'sd20;

	// Falling thermistor codes, one per degree
	localparam logic [SAMPLE_BITS-1:0] CODE_LIST [LISTED_CODES] = '{
		12'd3911, 12'd3901, 12'd3890, 12'd3878, 12'd3866, 12'd3853, 12'd3840, 12'd3827,
		12'd3813, 12'd3799, 12'd3784, 12'd3768, 12'd3752, 12'd3736, 12'd3719, 12'd3701,
		12'd3683, 12'd3664, 12'd3644, 12'd3624, 12'd3603, 12'd3582, 12'd3559, 12'd3537,
		12'd3513, 12'd3489, 12'd3464, 12'd3439, 12'd3412, 12'd3386, 12'd3358, 12'd3330,
		12'd3301, 12'd3271, 12'd3241, 12'd3210, 12'd3178, 12'd3146, 12'd3113, 12'd3080,
		12'd3046, 12'd3011, 12'd2976, 12'd2940, 12'd2903, 12'd2864, 12'd2829, 12'd2791,
		12'd2753, 12'd2714, 12'd2675, 12'd2636, 12'd2596, 12'd2556, 12'd2515, 12'd2475,
		12'd2434, 12'd2393, 12'd2352, 12'd2311, 12'd2270, 12'd2229, 12'd2188, 12'd2146,
		12'd2105, 12'd2064, 12'd2024, 12'd1983, 12'd1943, 12'd1903, 12'd1863, 12'd1823,
		12'd1784, 12'd1745, 12'd1707, 12'd1669, 12'd1631, 12'd1594, 12'd1557, 12'd1521,
		12'd1485, 12'd1450, 12'd1415, 12'd1381, 12'd1347, 12'd1314, 12'd1282, 12'd1250,
		12'd1218, 12'd1188, 12'd1157, 12'd1128, 12'd1099, 12'd1071, 12'd1043, 12'd1016,
		12'd989,  12'd963,  12'd938,  12'd913,  12'd889,  12'd865,  12'd842,  12'd819,
		12'd798,  12'd775,  12'd755,  12'd735,  12'd715,  12'd696,  12'd677,  12'd658,
		12'd641,  12'd623,  12'd606,  12'd590,  12'd574,  12'd558,  12'd543,  12'd528,
		12'd514,  12'd500,  12'd487,  12'd473,  12'd461,  12'd448,  12'd436,  12'd424,
		12'd413,  12'd402,  12'd391,  12'd381,  12'd370,  12'd360,  12'd351,  12'd342,
		12'd333,  12'd324,  12'd315,  12'd307,  12'd299,  12'd291,  12'd283,  12'd276,
		12'd269,  12'd262,  12'd255,  12'd248,  12'd242,  12'd236,  12'd230,  12'd224,
		12'd218,  12'd213,  12'd207,  12'd202,  12'd197,  12'd192,  12'd187,  12'd182,
		12'd178,  12'd173,  12'd169,  12'd165,  12'd161,  12'd157,  12'd153,  12'd149,
		12'd146,  12'd142,  12'd139,  12'd136,  12'd132,  12'd129,  12'd126,  12'd123,
		12'd120,  12'd117,  12'd115,  12'd112,  12'd109,  12'd107,  12'd104,  12'd102,
		12'd100,  12'd97,   12'd95,   12'd93,   12'd91,   12'd89,   12'd87,   12'd85,
		12'd83,   12'd81,   12'd79,   12'd77,   12'd76,   12'd74,   12'd72,   12'd71
	};

	// Divider request and response
	typedef struct packed {
		logic                   start;
		logic [SAMPLE_BITS-1:0] numer;
		logic [SAMPLE_BITS-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [QUOT_MAX_W-1:0] quot;
	} div_rsp_t;

	// Code of a table entry; entries past the list read as zero
	function automatic logic [SAMPLE_BITS-1:0] code_at(input logic [MAX_ENTRIES_W-1:0] idx);
		logic [SAMPLE_BITS-1:0] code;
		code = '0;
		if (idx < MAX_ENTRIES_W'(LISTED_CODES)) begin
			code = CODE_LIST[idx[7:0]];
		end
		return code;
	endfunction

endpackage

`default_nettype wire

/* design/ntc_if.sv */
// Handshake channels of the NTC unit: sample input, result output, register writes.
// Depends on ntc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ntc_sample_if import ntc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);
endinterface

interface ntc_result_if import ntc_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [SAMPLE_BITS-1:0]      corrected_sample;
	logic signed [TEMP_BITS-1:0] temperature_q8;
	logic                        out_of_range;

	modport source (output valid, output corrected_sample, output temperature_q8,
		output out_of_range, input ready);
	modport sink (input valid, input corrected_sample, input temperature_q8,
		input out_of_range, output ready);
endinterface

interface ntc_cfg_if import ntc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/ntc_adc_to_temperature_unit.sv */
// Top level of the NTC temperature unit: register port, search sequencer, output stage.
// Depends on ntc_pkg, ntc_if, ntc_code_rom, ntc_divider and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

// Converts one raw ADC sample at a time into a temperature in signed fixed point with
// FRACTION_BITS fraction bits. The offset is removed (floored at zero), the code table is
// checked at both ends, then binary-searched for the bracketing pair, and the fraction
// between the two codes comes from a serial divider. The search is paced by the single
// read port of the code table ROM, one access per cycle, and the fraction by the divider,
// which yields one quotient bit per cycle. A new sample is taken while the previous result
// still waits in the output register. Registers may be written at any time the unit is idle.

`include "ntc_adc_to_temperature_unit_macros.svh"

module ntc_adc_to_temperature_unit import ntc_pkg::*; #(
	parameter int TABLE_ENTRIES = 200,
	parameter int FRACTION_BITS = 8
) (
	input wire logic      clk,
	input wire logic      arst_n,
	ntc_sample_if.sink    sample,
	ntc_result_if.source  result,
	ntc_cfg_if.sink       cfg
);

	localparam int IDX_W  = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int QUOT_W = FRACTION_BITS + 1;
	localparam int SUM_W  = IDX_W + START_BITS + 1;
	localparam int WIDE_W = SUM_W + FRACTION_BITS + 2;
	localparam int SAT_W  = (WIDE_W > TEMP_BITS + 1) ? WIDE_W : TEMP_BITS + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic signed [SAT_W-1:0] TEMP_MAX = SAT_W'((2 ** (TEMP_BITS - 1)) - 1);
	localparam logic signed [SAT_W-1:0] TEMP_MIN = SAT_W'(-(2 ** (TEMP_BITS - 1)));

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_FIRST,
		S_CHK_LAST,
		S_SEARCH,
		S_RD_UP,
		S_RD_LO,
		S_DIV,
		S_OUT
	} state_t;

	state_t                         state_q;
	logic [OFFSET_BITS-1:0]         offset_q;
	logic signed [START_BITS-1:0]   start_q;
	logic [SAMPLE_BITS-1:0]         c_q;
	logic [IDX_W-1:0]               lo_q;
	logic [IDX_W-1:0]               hi_q;
	logic [IDX_W-1:0]               mid_q;
	logic [SAMPLE_BITS-1:0]         upper_q;
	logic                           flag_q;
	logic [QUOT_W-1:0]              quot_q;
	logic                           out_valid_q;
	logic [SAMPLE_BITS-1:0]         out_c_q;
	logic signed [TEMP_BITS-1:0]    out_temp_q;
	logic                           out_flag_q;

	logic [IDX_W-1:0]               rom_addr;
	logic [SAMPLE_BITS-1:0]         rom_data;
	logic [IDX_W-1:0]               lo_n;
	logic [IDX_W-1:0]               hi_n;
	logic [IDX_W:0]                 mid_sum;
	logic [IDX_W-1:0]               mid_n;
	logic [SAMPLE_BITS-1:0]         c_in;
	logic signed [SUM_W-1:0]        deg_sum;
	logic signed [SAT_W-1:0]        temp_wide;
	logic signed [TEMP_BITS-1:0]    temp_sat;
	logic                           out_free;
	div_req_t                       div_req;
	div_rsp_t                       div_rsp;

	ntc_code_rom #(
		.ENTRIES (TABLE_ENTRIES),
		.ADDR_W  (IDX_W)
	) u_rom (
		.clk     (clk),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	ntc_divider #(
		.FRAC_BITS (FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Take off the offset, floor at zero
	assign c_in = (sample.raw_sample > SAMPLE_BITS'(offset_q)) ?
		sample.raw_sample - SAMPLE_BITS'(offset_q) : '0;

	// Narrow the bracket and pick the next table address
	always_comb begin
		lo_n     = lo_q;
		hi_n     = hi_q;
		rom_addr = '0;
		case (state_q)
			S_CHK_LAST: begin
				lo_n = '0;
				hi_n = LAST_IDX;
			end
			S_SEARCH: begin
				if (rom_data >= c_q) begin
					lo_n = mid_q;
				end else begin
					hi_n = mid_q - IDX_W'(1);
				end
			end
			default: ;
		endcase
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n} + (IDX_W + 1)'(1);
		mid_n   = mid_sum[IDX_W:1];
		case (state_q)
			S_IDLE:      rom_addr = '0;
			S_CHK_FIRST: rom_addr = LAST_IDX;
			S_CHK_LAST:  rom_addr = mid_n;
			S_SEARCH:    rom_addr = (lo_n < hi_n) ? mid_n : lo_n;
			S_RD_UP:     rom_addr = lo_q + IDX_W'(1);
			default:     rom_addr = '0;
		endcase
	end

	// Start the divider once both bracketing codes are known and differ
	always_comb begin
		div_req.start = (state_q == S_RD_LO) && (upper_q > rom_data);
		div_req.numer = upper_q - c_q;
		div_req.denom = upper_q - rom_data;
	end

	// Whole degrees plus fraction, saturated to the output range
	always_comb begin
		deg_sum   = SUM_W'(start_q) + $signed(SUM_W'(lo_q));
		temp_wide = (SAT_W'(deg_sum) <<< FRACTION_BITS) + $signed(SAT_W'(quot_q));
		if (temp_wide > TEMP_MAX) begin
			temp_sat = TEMP_BITS'(TEMP_MAX);
		end else if (temp_wide < TEMP_MIN) begin
			temp_sat = TEMP_BITS'(TEMP_MIN);
		end else begin
			temp_sat = TEMP_BITS'(temp_wide);
		end
	end

	assign out_free = !out_valid_q || result.ready;

	// Hold state, registers and the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			offset_q    <= OFFSET_RESET;
			start_q     <= START_RESET;
			c_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			upper_q     <= '0;
			flag_q      <= 1'b0;
			quot_q      <= '0;
			out_valid_q <= 1'b0;
			out_c_q     <= '0;
			out_temp_q  <= '0;
			out_flag_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_OFFSET:            offset_q <= cfg.data;
					REG_START_TEMPERATURE: start_q  <= $signed(cfg.data[START_BITS-1:0]);
					default: ;
				endcase
			end
			// Present a finished item, drop it once taken
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						c_q     <= c_in;
						flag_q  <= 1'b0;
						quot_q  <= '0;
						state_q <= S_CHK_FIRST;
					end
				end
				S_CHK_FIRST: begin
					if (c_q > rom_data) begin
						lo_q    <= '0;
						flag_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CHK_LAST;
					end
				end
				S_CHK_LAST: begin
					if (c_q < rom_data) begin
						lo_q    <= LAST_IDX;
						flag_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						lo_q    <= lo_n;
						hi_q    <= hi_n;
						mid_q   <= mid_n;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
					if (!(lo_n < hi_n)) begin
						state_q <= S_RD_UP;
					end
				end
				S_RD_UP: begin
					upper_q <= rom_data;
					state_q <= (lo_q == LAST_IDX) ? S_OUT : S_RD_LO;
				end
				S_RD_LO: begin
					state_q <= (upper_q > rom_data) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						quot_q  <= div_rsp.quot[QUOT_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_c_q     <= c_q;
						out_temp_q  <= temp_sat;
						out_flag_q  <= flag_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready            = (state_q == S_IDLE);
	assign cfg.ready               = 1'b1;
	assign result.valid            = out_valid_q;
	assign result.corrected_sample = out_c_q;
	assign result.temperature_q8   = out_temp_q;
	assign result.out_of_range     = out_flag_q;

	`NTC_ASSERT_NXT(a_accept_start, clk, arst_n, sample.valid && sample.ready, state_q == S_CHK_FIRST, "accepted item did not start the end checks")
	`NTC_ASSERT_IMP(a_search_open, clk, arst_n, state_q == S_SEARCH, lo_q < hi_q, "search entered with an empty bracket")
	`NTC_ASSERT_IMP(a_div_owner, clk, arst_n, div_rsp.done, state_q == S_DIV, "divider finished outside the divide wait")
	`NTC_ASSERT_NXT(a_out_load, clk, arst_n, (state_q == S_OUT) && out_free, result.valid, "finished item not presented")

endmodule

`default_nettype wire

/* design/ntc_code_rom.sv */
// Thermistor code table as a synchronous ROM with one registered read port.
// Depends on ntc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntc_code_rom import ntc_pkg::*; #(
	parameter int ENTRIES = 200,
	parameter int ADDR_W  = 8
) (
	input  wire logic                   clk,
	input  wire logic [ADDR_W-1:0]      rd_addr,
	output logic      [SAMPLE_BITS-1:0] rd_data
);

	logic [SAMPLE_BITS-1:0] rd_data_q;

	// Register the read; addresses past the depth read as zero
	always_ff @(posedge clk) begin
		if (rd_addr < ADDR_W'(ENTRIES - 1) || rd_addr == ADDR_W'(ENTRIES - 1)) begin
			rd_data_q <= code_at(MAX_ENTRIES_W'(rd_addr));
		end else begin
			rd_data_q <= '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* design/ntc_divider.sv */
// Restoring serial divider for the interpolation fraction, one quotient bit a cycle.
// Depends on ntc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "ntc_adc_to_temperature_unit_macros.svh"

module ntc_divider import ntc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int QUOT_W = FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS + 2);
	localparam logic [QUOT_W-1:0] QUOT_MAX = QUOT_W'(1) << FRAC_BITS;

	logic [CNT_W-1:0]       cnt_q;
	logic                   first_q;
	logic                   done_q;
	logic [SAMPLE_BITS:0]   rem_q;
	logic [SAMPLE_BITS-1:0] denom_q;
	logic [QUOT_W-1:0]      quot_q;
	logic [SAMPLE_BITS:0]   trial;
	logic                   fits;

	// First step compares the numerator as is; later steps shift in a zero
	always_comb begin
		trial = first_q ? rem_q : {rem_q[SAMPLE_BITS-1:0], 1'b0};
		fits  = trial >= {1'b0, denom_q};
	end

	// Load on start, then advance one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			rem_q   <= '0;
			denom_q <= '0;
			quot_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q   <= CNT_W'(QUOT_W);
				first_q <= 1'b1;
				rem_q   <= {1'b0, req.numer};
				denom_q <= req.denom;
				quot_q  <= '0;
			end else if (cnt_q != '0) begin
				cnt_q   <= cnt_q - CNT_W'(1);
				first_q <= 1'b0;
				rem_q   <= fits ? trial - {1'b0, denom_q} : trial;
				quot_q  <= {quot_q[QUOT_W-2:0], fits};
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = QUOT_MAX_W'(quot_q);

	`NTC_ASSERT_IMP(a_start_idle, clk, arst_n, req.start, cnt_q == '0, "divider restarted while busy")
	`NTC_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q, "divider done held longer than one cycle")
	`NTC_ASSERT_IMP(a_quot_bound, clk, arst_n, done_q, quot_q <= QUOT_MAX, "fraction exceeds one degree")

endmodule

`default_nettype wire
